[design/utf8d_pkg.sv]
// Shared types, constants and byte-class helpers for the UTF-8 decoder.
// No dependencies; every other design file imports this package.
`default_nettype none

package utf8d_pkg;

	localparam logic [20:0] REPLACEMENT  = 21'h00FFFD;
	localparam logic [20:0] MAX_CP       = 21'h10FFFF;
	localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
	localparam logic [20:0] PLANE1_BASE  = 21'h010000;
	localparam logic [20:0] SURR_HI_BASE = 21'h00D800;
	localparam logic [20:0] SURR_LO_BASE = 21'h00DC00;
	localparam logic [15:0] SURR_FIRST   = 16'hD800;
	localparam logic [15:0] SURR_LAST    = 16'hDFFF;
	localparam logic [10:0] MIN_CP2      = 11'h080;
	localparam logic [15:0] MIN_CP3      = 16'h0800;

	// Register index of the output-mode bit on the configuration port
	localparam logic [0:0]  CFG_UTF16    = 1'b0;

	// One scan step at one window position
	typedef struct packed {
		logic [1:0]  nunits;  // 0, 1 or 2 code units
		logic        hold;    // incomplete sequence: keep the rest of the window
		logic [2:0]  adv;     // bytes consumed
		logic [20:0] u0;
		logic [20:0] u1;
	} tok_t;

	// Results caused by one input byte, in order
	typedef struct packed {
		logic [2:0]       count;
		logic [3:0][20:0] units;
		logic [3:0]       eot;
	} batch_t;

	// Sequence length announced by a lead byte; 0 for a byte that cannot lead
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		if (!b[7])
			return 3'd1;
		else if (b[7:5] == 3'b110)
			return 3'd2;
		else if (b[7:4] == 4'b1110)
			return 3'd3;
		else if (b[7:3] == 5'b11110)
			return 3'd4;
		else
			return 3'd0;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

`default_nettype wire

[design/utf8d_decode.sv]
// Combinational decode of one byte against the held sequence.
// Depends on utf8d_pkg for types, constants and lead_len/is_cont.
`default_nettype none

module utf8d_decode import utf8d_pkg::*; (
	input  logic [7:0]      byte_in,
	input  logic [2:0][7:0] held,
	input  logic [1:0]      held_cnt,
	input  logic            utf16,
	output batch_t          batch,
	output logic [2:0][7:0] held_next,
	output logic [1:0]      held_cnt_next
);

	// Decode the sequence that starts at s[0], with avail bytes present
	function automatic tok_t tok_at(input logic [3:0][7:0] s, input logic [2:0] avail,
		input logic term, input logic mode16);
		tok_t        t;
		logic [2:0]  n;
		logic [10:0] cp2;
		logic [15:0] cp3;
		logic [20:0] cp4;
		logic [20:0] cp;
		logic [19:0] off;
		logic        ok;
		t   = '{nunits: 2'd1, hold: 1'b0, adv: 3'd1, u0: REPLACEMENT, u1: '0};
		n   = lead_len(s[0]);
		cp2 = {s[0][4:0], s[1][5:0]};
		cp3 = {s[0][3:0], s[1][5:0], s[2][5:0]};
		cp4 = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
		cp  = '0;
		ok  = 1'b0;
		case (n)
			3'd2: begin
				cp = {10'b0, cp2};
				ok = (cp2 >= MIN_CP2) && is_cont(s[1]);
			end
			3'd3: begin
				cp = {5'b0, cp3};
				ok = (cp3 >= MIN_CP3) && !(cp3 >= SURR_FIRST && cp3 <= SURR_LAST) &&
				     is_cont(s[1]) && is_cont(s[2]);
			end
			3'd4: begin
				cp = cp4;
				ok = (cp4 >= PLANE1_BASE) && (cp4 <= MAX_CP) &&
				     is_cont(s[1]) && is_cont(s[2]) && is_cont(s[3]);
			end
			default: ;
		endcase
		off = 20'(cp - PLANE1_BASE);
		if (n == 3'd1) begin
			t.u0 = {13'b0, s[0]};
		end else if (n >= 3'd2) begin
			if (avail >= n) begin
				// a failed check consumes only the lead; the rest is scanned again
				if (ok) begin
					t.adv = n;
					if (mode16 && cp > BMP_MAX) begin
						t.nunits = 2'd2;
						t.u0     = SURR_HI_BASE + {11'b0, off[19:10]};
						t.u1     = SURR_LO_BASE + {11'b0, off[9:0]};
					end else begin
						t.u0 = cp;
					end
				end
			end else if (!term) begin
				t.hold   = 1'b1;
				t.nunits = 2'd0;
				t.adv    = 3'd0;
			end
		end
		return t;
	endfunction

	logic            is_zero;
	logic [3:0][7:0] win;
	logic [2:0]      win_len;
	tok_t [3:0]      toks;
	logic [3:0][7:0] rest;
	logic [2:0]      pos;
	logic [2:0]      hold_pos;
	logic            stop;
	tok_t            t;
	logic [2:0]      cnt;

	assign is_zero = (byte_in == 8'd0);

	// Window: held bytes followed by the new byte; a zero byte only flushes
	always_comb begin
		for (int j = 0; j < 3; j++)
			win[j] = (2'(j) < held_cnt) ? held[j] : byte_in;
		win[3]  = byte_in;
		win_len = is_zero ? {1'b0, held_cnt} : ({1'b0, held_cnt} + 3'd1);
		for (int i = 0; i < 4; i++)
			toks[i] = tok_at(win >> (8 * i), win_len - 3'(i), is_zero, utf16);
	end

	// Walk the window position by position and pack the code units
	always_comb begin
		pos      = 3'd0;
		hold_pos = win_len;
		stop     = 1'b0;
		cnt      = 3'd0;
		t        = '0;
		batch    = '0;
		for (int k = 0; k < 4; k++) begin
			if (!stop && pos < win_len) begin
				t = toks[pos[1:0]];
				if (t.hold) begin
					stop     = 1'b1;
					hold_pos = pos;
				end else begin
					if (t.nunits != 2'd0 && cnt < 3'd4) begin
						batch.units[cnt[1:0]] = t.u0;
						cnt = cnt + 3'd1;
					end
					if (t.nunits == 2'd2 && cnt < 3'd4) begin
						batch.units[cnt[1:0]] = t.u1;
						cnt = cnt + 3'd1;
					end
					pos = pos + t.adv;
				end
			end
		end
		// end marker, dropped if the result limit is already reached
		if (is_zero && cnt < 3'd4) begin
			batch.units[cnt[1:0]] = '0;
			batch.eot[cnt[1:0]]   = 1'b1;
			cnt = cnt + 3'd1;
		end
		batch.count = cnt;
	end

	assign rest          = win >> {hold_pos, 3'b000};
	assign held_next     = rest[2:0];
	assign held_cnt_next = stop ? 2'(win_len - hold_pos) : 2'd0;

endmodule

`default_nettype wire

[design/utf8d_out_buf.sv]
// Result buffer: loads a byte's batch, drains one a cycle if not stalled.
// Depends on utf8d_pkg for batch_t.
`default_nettype none

module utf8d_out_buf import utf8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  batch_t      batch,
	output logic        ready,
	output logic        unit_valid,
	input  logic        unit_stall,
	output logic [20:0] code_unit,
	output logic        end_of_text,
	output logic        last
);

	logic [3:0][20:0] unit_q;
	logic [3:0]       eot_q;
	logic [2:0]       cnt_q;
	logic [1:0]       idx_q;
	logic             take;

	assign unit_valid  = (cnt_q != 3'd0);
	assign take        = unit_valid && !unit_stall;
	assign ready       = (cnt_q == 3'd0) || (cnt_q == 3'd1 && !unit_stall);
	assign code_unit   = unit_q[idx_q];
	assign end_of_text = eot_q[idx_q];
	assign last        = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.count;
			idx_q <= 2'd0;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q <= batch.units;
			eot_q  <= batch.eot;
		end
	end

endmodule

`default_nettype wire

[design/utf8_decoder_with_replacement_core.sv]
// Top level of the UTF-8 decoder with replacement: input register, held state,
// config register. Depends on utf8d_pkg, utf8d_decode and utf8d_out_buf.
//
//   channel   direction  handshake                 payload
//   byte      in         byte_valid / byte_stall   byte_in[7:0]
//   unit      out        unit_valid / unit_stall   code_unit[20:0], end_of_text, last
//   config    in         APB psel/penable/pwrite   paddr[2:0], pwdata, prdata
//
// A byte is taken into the input register and decoded in the next cycle. Its
// results load into the result buffer when the buffer is ready, and the first
// result is presented from the buffer. Bytes that give at most one result
// stream at one per cycle while unit_stall is low; a byte that gives more
// results (up to four) holds back the next byte while the buffer drains, one
// unit a cycle when not stalled.
// Reset clears the held count, the mode bit and all valid flags; no sweep.
// A stall on the unit side holds the buffer, then the input register, then byte_stall.
`default_nettype none

module utf8_decoder_with_replacement_core import utf8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_in,
	output logic        unit_valid,
	input  logic        unit_stall,
	output logic [20:0] code_unit,
	output logic        end_of_text,
	output logic        last
);

	logic            utf16_q;
	logic [2:0][7:0] held_q;
	logic [1:0]      held_cnt_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;

	batch_t          batch;
	logic [2:0][7:0] held_next;
	logic [1:0]      held_cnt_next;
	logic            buf_ready;
	logic            retire;
	logic            accept;

	// Config port: single mode bit, zero-wait
	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == CFG_UTF16) ? {31'b0, utf16_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			utf16_q <= 1'b0;
		else if (psel && penable && pwrite && pready && paddr[2:2] == CFG_UTF16)
			utf16_q <= pwdata[0];
	end

	// Retire the registered byte once its batch fits in the result buffer;
	// a byte that only extends the held sequence retires at once.
	assign retire     = valid_s1 && (batch.count == 3'd0 || buf_ready);
	assign byte_stall = valid_s1 && !retire;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (retire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_s1 <= byte_in;
	end

	// Held sequence advances only when a byte retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_cnt_q <= 2'd0;
		else if (retire)
			held_cnt_q <= held_cnt_next;
	end

	always_ff @(posedge clk) begin
		if (retire)
			held_q <= held_next;
	end

	utf8d_decode u_decode (
		.byte_in       (byte_s1),
		.held          (held_q),
		.held_cnt      (held_cnt_q),
		.utf16         (utf16_q),
		.batch         (batch),
		.held_next     (held_next),
		.held_cnt_next (held_cnt_next)
	);

	utf8d_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (retire && batch.count != 3'd0),
		.batch       (batch),
		.ready       (buf_ready),
		.unit_valid  (unit_valid),
		.unit_stall  (unit_stall),
		.code_unit   (code_unit),
		.end_of_text (end_of_text),
		.last        (last)
	);

	// Held sequence always starts with a multi-byte lead
	a_held_lead: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != 2'd0 |-> lead_len(held_q[0]) >= 3'd2)
		else $error("held sequence without a multi-byte lead");

	// End marker is the final unit of its batch and carries zero
	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && end_of_text |-> last && code_unit == 21'd0)
		else $error("end marker not last or not zero");

	// Zero byte leaves nothing held
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		retire && byte_s1 == 8'd0 |=> held_cnt_q == 2'd0)
		else $error("held bytes survive a zero byte");

	// A nonzero byte without results must have been held
	a_silent_held: assert property (@(posedge clk) disable iff (!arst_n)
		retire && byte_s1 != 8'd0 && batch.count == 3'd0 |=> held_cnt_q != 2'd0)
		else $error("byte dropped without result or hold");

endmodule

`default_nettype wire

[tb/utf8_decoder_with_replacement_core_tb.sv]
// Self-checking testbench for utf8_decoder_with_replacement_core.
// Drives UTF-8 bytes and the output-mode register, and checks every code unit
// against a decode scoreboard. Depends on utf8d_pkg and the decoder RTL.
`default_nettype none

module utf8_decoder_with_replacement_core_tb import utf8d_pkg::*;;

	// Byte address of the output-mode register on the APB port
	localparam logic [2:0] MODE_ADDR = {CFG_UTF16, 2'b00};

	// One expected result: the unit, the end marker flag and the final-of-byte flag
	typedef struct packed {
		logic [20:0] code;
		logic        eot;
		logic        tail;
	} unit_t;

	// Tracks the decoder state and keeps the code units still owed by the block
	class decode_scoreboard;
		unit_t       expected_units[$];
		unit_t       batch[$];
		logic [7:0]  held[3];
		int unsigned held_n;
		logic        utf16;
		int unsigned failures;

		function new();
			held = '{8'h00, 8'h00, 8'h00};
			held_n = 0;
			utf16 = 1'b0;
			failures = 0;
		endfunction

		function int unsigned pending();
			return expected_units.size();
		endfunction

		// At most four units leave for one byte
		function void push_unit(logic [20:0] code, logic eot);
			unit_t u;
			if (batch.size() >= 4)
				return;
			u.code = code;
			u.eot = eot;
			u.tail = 1'b0;
			batch = {batch, u};
		endfunction

		function void push_point(logic [20:0] cp);
			logic [20:0] off;
			if (utf16 && cp > BMP_MAX) begin
				off = cp - PLANE1_BASE;
				push_unit(SURR_HI_BASE + off[19:10], 1'b0);
				push_unit(SURR_LO_BASE + off[9:0], 1'b0);
			end else begin
				push_unit(cp, 1'b0);
			end
		endfunction

		function int unsigned seq_len(logic [7:0] b);
			casez (b)
				8'b0???????: return 1;
				8'b110?????: return 2;
				8'b1110????: return 3;
				8'b11110???: return 4;
				default:     return 0;
			endcase
		endfunction

		function logic cont(logic [7:0] b);
			return b[7:6] == 2'b10;
		endfunction

		function logic seq_ok(logic [7:0] s[4], int unsigned n, output logic [20:0] cp);
			logic [31:0] v;
			logic        ok;
			case (n)
				2: begin
					v = {21'b0, s[0][4:0], s[1][5:0]};
					ok = v >= MIN_CP2 && cont(s[1]);
				end
				3: begin
					v = {16'b0, s[0][3:0], s[1][5:0], s[2][5:0]};
					ok = v >= MIN_CP3 && !(v >= SURR_FIRST && v <= SURR_LAST) &&
						cont(s[1]) && cont(s[2]);
				end
				default: begin
					v = {11'b0, s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
					ok = v >= PLANE1_BASE && v <= MAX_CP &&
						cont(s[1]) && cont(s[2]) && cont(s[3]);
				end
			endcase
			cp = v[20:0];
			return ok;
		endfunction

		// Feed bytes through the decoder state; a failed sequence puts its
		// trailing bytes back in front to be scanned as new leads
		function void scan(logic [7:0] bytes[$]);
			logic [7:0]  work[$];
			logic [7:0]  c;
			logic [7:0]  seq[4];
			logic [20:0] cp;
			int unsigned n;
			int unsigned k;
			work = bytes;
			while (work.size() > 0) begin
				c = work.pop_front();
				if (held_n == 0) begin
					n = seq_len(c);
					if (n == 1)
						push_point({13'b0, c});
					else if (n == 0)
						push_unit(REPLACEMENT, 1'b0);
					else begin
						held[0] = c;
						held_n = 1;
					end
					continue;
				end
				n = seq_len(held[0]);
				if (n < 2)
					n = 2;
				if (held_n + 1 < n) begin
					held[held_n] = c;
					held_n++;
					continue;
				end
				k = held_n - 1;
				seq[0] = held[0];
				seq[1] = held[1];
				seq[2] = held[2];
				seq[3] = 8'h00;
				seq[n - 1] = c;
				held_n = 0;
				if (seq_ok(seq, n, cp)) begin
					push_point(cp);
					continue;
				end
				push_unit(REPLACEMENT, 1'b0);
				if (work.size() + k + 1 > 8)
					continue;
				work.push_front(c);
				for (int i = k; i > 0; i--)
					work.push_front(seq[i]);
			end
		endfunction

		function void note_byte(logic [7:0] b);
			logic [7:0]  work[$];
			int unsigned k;
			batch = {};
			if (b != 8'h00) begin
				work = {b};
				scan(work);
			end else begin
				while (held_n > 0) begin
					k = held_n - 1;
					if (k > 2)
						k = 2;
					work = {};
					for (int i = 1; i <= k; i++)
						work = {work, held[i]};
					held_n = 0;
					push_unit(REPLACEMENT, 1'b0);
					scan(work);
				end
				push_unit(21'h0, 1'b1);
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].tail = 1'b1;
			expected_units = {expected_units, batch};
		endfunction

		function void check_unit(logic [20:0] code, logic eot, logic fin);
			unit_t want;
			if (expected_units.size() == 0) begin
				failures++;
				$display("%0t: expected no unit, actual %h eot %b last %b",
					$time, code, eot, fin);
				return;
			end
			want = expected_units.pop_front();
			if (code !== want.code) begin
				failures++;
				$display("%0t: code_unit expected %h, actual %h", $time, want.code, code);
			end
			if (eot !== want.eot) begin
				failures++;
				$display("%0t: end_of_text expected %b, actual %b", $time, want.eot, eot);
			end
			if (fin !== want.tail) begin
				failures++;
				$display("%0t: last expected %b, actual %b", $time, want.tail, fin);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'b0;
	logic [31:0] pwdata = 32'b0;
	logic [31:0] prdata;
	logic        pready;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  byte_in = 8'h00;
	logic        unit_valid;
	logic        unit_stall = 1'b0;
	logic [20:0] code_unit;
	logic        end_of_text;
	logic        last;

	// Random idling on both channels while set
	bit          throttle = 1'b1;
	logic [7:0]  text_bytes[$];
	decode_scoreboard sb = new();

	utf8_decoder_with_replacement_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_in     (byte_in),
		.unit_valid  (unit_valid),
		.unit_stall  (unit_stall),
		.code_unit   (code_unit),
		.end_of_text (end_of_text),
		.last        (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Monitor both channels at the edge: check the result first, then note the
	// byte, so a byte accepted at this edge never answers for an older unit
	always @(posedge clk) begin
		if (unit_valid && !unit_stall)
			sb.check_unit(code_unit, end_of_text, last);
		if (byte_valid && !byte_stall)
			sb.note_byte(byte_in);
	end

	// Back-pressure the unit channel at random while throttling
	always @(posedge clk) begin
		unit_stall <= throttle && ($urandom_range(99) < 22);
	end

	// Pick a well-formed code point for a sequence of n bytes
	function automatic logic [20:0] valid_point(int unsigned n);
		logic [20:0] cp;
		case (n)
			2: cp = 21'($urandom_range(21'h0007FF, 21'h000080));
			3: begin
				cp = 21'($urandom_range(21'h00FFFF, 21'h000800));
				// move surrogates out of the way
				if (cp >= SURR_HI_BASE && cp <= {5'b0, SURR_LAST})
					cp = cp ^ 21'h004000;
			end
			default: cp = 21'($urandom_range(21'h10FFFF, 21'h010000));
		endcase
		return cp;
	endfunction

	// Append cp encoded in n bytes; small values give overlong forms
	function automatic void add_encoded(logic [20:0] cp, int unsigned n);
		case (n)
			2: begin
				text_bytes = {text_bytes, {3'b110, cp[10:6]}};
				text_bytes = {text_bytes, {2'b10, cp[5:0]}};
			end
			3: begin
				text_bytes = {text_bytes, {4'b1110, cp[15:12]}};
				text_bytes = {text_bytes, {2'b10, cp[11:6]}};
				text_bytes = {text_bytes, {2'b10, cp[5:0]}};
			end
			default: begin
				text_bytes = {text_bytes, {5'b11110, cp[20:18]}};
				text_bytes = {text_bytes, {2'b10, cp[17:12]}};
				text_bytes = {text_bytes, {2'b10, cp[11:6]}};
				text_bytes = {text_bytes, {2'b10, cp[5:0]}};
			end
		endcase
	endfunction

	// Build random text: mostly well-formed sequences, the rest noise, cut-off
	// sequences, damaged continuations, terminators and forbidden values
	task automatic plan_text(input int unsigned budget);
		int unsigned pick;
		int unsigned n;
		int unsigned start;
		while (text_bytes.size() < budget) begin
			pick = $urandom_range(99);
			n = $urandom_range(4, 2);
			start = text_bytes.size();
			if (pick < 25) begin
				text_bytes = {text_bytes, 8'($urandom_range(127, 1))};
			end else if (pick < 70) begin
				add_encoded(valid_point(n), n);
			end else if (pick < 77) begin
				text_bytes = {text_bytes, 8'h00};
			end else if (pick < 84) begin
				text_bytes = {text_bytes, 8'($urandom_range(255))};
			end else if (pick < 90) begin
				// drop the tail, then end the text or run into the next byte
				add_encoded(valid_point(n), n);
				repeat ($urandom_range(n - 1, 1))
					void'(text_bytes.pop_back());
				if ($urandom_range(1))
					text_bytes = {text_bytes, 8'h00};
			end else if (pick < 95) begin
				add_encoded(valid_point(n), n);
				text_bytes[start + $urandom_range(n - 1, 1)] = 8'($urandom_range(255));
			end else begin
				case ($urandom_range(2))
					0: add_encoded(n == 2 ? 21'($urandom_range(21'h00007F)) :
						n == 3 ? 21'($urandom_range(21'h0007FF)) :
						21'($urandom_range(21'h00FFFF)), n);
					1: add_encoded(21'($urandom_range(21'h00DFFF, 21'h00D800)), 3);
					default: add_encoded(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
				endcase
			end
		end
	endtask

	// Send every planned byte; hold valid high across back-to-back transactions
	task automatic send_text();
		while (text_bytes.size() > 0) begin
			while (throttle && $urandom_range(99) < 22) begin
				byte_valid <= 1'b0;
				@(posedge clk);
			end
			byte_valid <= 1'b1;
			byte_in <= text_bytes.pop_front();
			@(posedge clk);
			while (byte_stall)
				@(posedge clk);
		end
		byte_valid <= 1'b0;
	endtask

	// Wait for every owed unit, then let a held byte finish inside the block
	task automatic settle();
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (8)
			@(posedge clk);
	endtask

	// APB write of the output-mode bit: setup cycle, then access cycle
	task automatic write_mode(input logic mode);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MODE_ADDR;
		pwdata <= {31'b0, mode};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.utf16 = mode;
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed text in UTF-16 mode so the top code point leaves as a pair
		write_mode(1'b1);
		text_bytes = '{
			8'h7F,                       // highest ASCII byte
			8'hC3, 8'hA9,                // two-byte character
			8'hE2, 8'h82, 8'hAC,         // three-byte character
			8'hF4, 8'h8F, 8'hBF, 8'hBF,  // U+10FFFF, surrogate pair
			8'hFF,                       // stray byte above the lead range
			8'hC0, 8'h80,                // overlong lead, rescan of the stray 0x80
			8'hED, 8'hA0, 8'h80,         // encoded surrogate, rescan of both trailers
			8'hF5, 8'h80, 8'h80, 8'h80,  // beyond U+10FFFF: four replacements
			8'hC3, 8'h41,                // bad continuation, ASCII comes back out
			8'hE2, 8'h82, 8'h00,         // text cut short by the terminator
			8'h00                        // terminator with nothing held
		};
		send_text();
		settle();

		// Random text in code-point mode with idling on both sides
		write_mode(1'b0);
		plan_text(30);
		send_text();
		settle();

		// Random text in UTF-16 mode at full rate
		write_mode(1'b1);
		throttle = 1'b0;
		plan_text(30);
		send_text();
		settle();

		// Random text in UTF-16 mode with idling again
		throttle = 1'b1;
		plan_text(24);
		send_text();
		settle();

		if (sb.failures == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
design/utf8d_pkg.sv
design/utf8d_decode.sv
design/utf8d_out_buf.sv
design/utf8_decoder_with_replacement_core.sv
tb/utf8_decoder_with_replacement_core_tb.sv
